// ===== rtl/subnet_mask_match_table_unit_macros.svh =====
// Assertion macros for the subnet mask match table.
`ifndef SUBNET_MASK_MATCH_TABLE_UNIT_MACROS_SVH
`define SUBNET_MASK_MATCH_TABLE_UNIT_MACROS_SVH

// Checks that prop holds at every rising edge of clk outside reset.
`define SMMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that cond at one edge implies prop at the next edge.
`define SMMT_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/smmt_pkg.sv =====
// Shared types and constants of the subnet mask match table.
package smmt_pkg;

  localparam int DEFAULT_MAX_ENTRIES = 64;
  localparam int ADDR_W = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // A lookup request walking down the row of cells.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] address;
    logic              hit;
  } smmt_query_t;

  // Insert request broadcast to all cells; only the cell at the fill index takes it.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
  } smmt_write_t;

endpackage

// ===== rtl/smmt_cell.sv =====
// One table entry: holds a prefix and mask and checks a passing lookup request.
module smmt_cell #(
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CNT_W-1:0]    count,
  input  smmt_pkg::smmt_write_t wr,
  input  smmt_pkg::smmt_query_t query_in,
  output smmt_pkg::smmt_query_t query_out
);

  logic [smmt_pkg::ADDR_W-1:0] prefix;
  logic [smmt_pkg::ADDR_W-1:0] mask;
  logic                        active;
  logic                        match;

  // The entry holds a subnet only once the fill count has passed it.
  assign active = (CNT_W'(INDEX) < count);
  assign match  = active && ((query_in.address & mask) == prefix);

  always_ff @(posedge clk) begin
    if (wr.en && (count == CNT_W'(INDEX))) begin
      prefix <= wr.prefix;
      mask   <= wr.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_out.valid <= 1'b0;
    end else begin
      query_out.valid <= query_in.valid;
    end
    query_out.address <= query_in.address;
    query_out.hit     <= query_in.hit | match;
  end

endmodule

// ===== rtl/subnet_mask_match_table_unit.sv =====
// Top level of the subnet mask match table: request control and the row of cells.
//
// Holds up to MAX_ENTRIES IPv4 subnets. An insert request stores address AND netmask
// with the netmask in the next free entry, or reports dropped when the table is full;
// a lookup request reports hit when the address lies in any stored subnet. One request
// is worked on at a time. An insert result is registered and then moved to the output register;
// a lookup result is registered once the request has stepped through the row of
// entry cells one cell per clock. A new request is accepted while the previous result
// still waits in the output register. Entries are never removed; reset empties the table.
module subnet_mask_match_table_unit #(
  parameter int MAX_ENTRIES = smmt_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // [31:0] address, [63:32] netmask
  input  logic [0:0]  s_tuser,  // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata   // [0] hit, [1] dropped, [7:2] zero
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] count;
  logic             full;
  logic             s_fire;
  logic             is_insert;
  logic             res_hit;
  logic             res_dropped;
  logic             out_free;
  logic             out_hit;
  logic             out_dropped;

  smmt_pkg::smmt_write_t wr;
  smmt_pkg::smmt_query_t chain [0:MAX_ENTRIES];

  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign is_insert = (s_tuser[0] == smmt_pkg::CMD_INSERT);
  assign full      = (count == CNT_W'(MAX_ENTRIES));
  assign out_free  = !m_tvalid || m_tready;

  assign wr.en     = s_fire && is_insert && !full;
  assign wr.prefix = s_tdata[31:0] & s_tdata[63:32];
  assign wr.mask   = s_tdata[63:32];

  assign chain[0].valid   = s_fire && !is_insert;
  assign chain[0].address = s_tdata[31:0];
  assign chain[0].hit     = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    smmt_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .count     (count),
      .wr        (wr),
      .query_in  (chain[i]),
      .query_out (chain[i+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          state_next = is_insert ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (chain[MAX_ENTRIES].valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr.en) begin
        count <= count + CNT_W'(1);
      end
      if ((state == ST_FINISH) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && is_insert) begin
      res_hit     <= 1'b0;
      res_dropped <= full;
    end else if ((state == ST_RUN) && chain[MAX_ENTRIES].valid) begin
      res_hit     <= chain[MAX_ENTRIES].hit;
      res_dropped <= 1'b0;
    end
    if ((state == ST_FINISH) && out_free) begin
      out_hit     <= res_hit;
      out_dropped <= res_dropped;
    end
  end

  assign m_tdata = {6'b0, out_dropped, out_hit};

`include "subnet_mask_match_table_unit_macros.svh"

  `SMMT_ASSERT(a_count_bound, count <= CNT_W'(MAX_ENTRIES), "fill count exceeds table size")
  `SMMT_ASSERT(a_tail_in_run, !chain[MAX_ENTRIES].valid || (state == ST_RUN), "lookup left the row outside RUN")
  `SMMT_ASSERT(a_drop_when_full, !((state == ST_FINISH) && res_dropped) || full, "insert dropped with free entries")
  `SMMT_ASSERT_NEXT(a_count_frozen, state == ST_RUN, $stable(count), "fill count changed during a lookup")

endmodule
